// File: rtl/bcge_pkg.sv
package bcge_pkg;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int WAIT_DEPTH_DEF = 4;
    localparam int BLK_W = 31;
    localparam int PID_W = 16;
    localparam int ST_W  = 3;
    localparam int IDX_W = 3;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_QUEUED   = 3'd2,
        ST_NO_FREE  = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NOT_BUSY = 3'd5,
        ST_WOKEN    = 3'd6,
        ST_WAIT_FULL = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FSCAN,
        S_SHIFT,
        S_WAKE,
        S_DONE
    } t_state;

endpackage

// File: rtl/buffer_cache_getblk_engine.sv
// Buffer-cache tag and lock engine. Pulse start with an action (0 request,
// 1 release), block number and pid while busy is low. Results come out at
// most one word per cycle on o_valid, and o_last marks the final word of an
// item; the receiver cannot stall, so every word must be taken when shown.
// A single comparator walks the slots one per cycle for the tag search, and
// a decision follows. A free hit then finds and closes up its free-list
// entry, a miss closes up the free-list head, and a release of a locked
// block wakes each waiter with one word and then returns the slot to the
// free list.
module buffer_cache_getblk_engine #(
    parameter int NUM_SLOTS  = bcge_pkg::NUM_SLOTS_DEF,
    parameter int WAIT_DEPTH = bcge_pkg::WAIT_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [bcge_pkg::BLK_W-1:0] i_block_number,
    input  logic [bcge_pkg::PID_W-1:0] i_process_id,
    output logic                      o_valid,
    output logic [bcge_pkg::ST_W-1:0]  o_status,
    output logic [bcge_pkg::IDX_W-1:0] o_buffer_index,
    output logic [bcge_pkg::PID_W-1:0] o_woken_pid,
    output logic                      o_last
);
    import bcge_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int NW = $clog2(WAIT_DEPTH + 1);
    localparam int MW = $clog2(NUM_SLOTS * WAIT_DEPTH);

    logic [BLK_W-1:0]  r_tag [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_used, r_lock;
    logic [SW-1:0]     r_free [NUM_SLOTS];
    logic [CW-1:0]     r_fcnt;
    logic [NW-1:0]     r_wcnt [NUM_SLOTS];
    logic [PID_W-1:0]  r_wmem [NUM_SLOTS*WAIT_DEPTH];

    t_state r_state, n_state;
    logic             r_act;
    logic [BLK_W-1:0] r_blk;
    logic [PID_W-1:0] r_pid;
    logic [CW-1:0]    r_i;
    logic             r_hit;
    logic [SW-1:0]    r_slot;
    logic [NW-1:0]    r_n;

    logic             r_ov, r_olast;
    t_status          r_ost;
    logic [IDX_W-1:0] r_oidx;
    logic [PID_W-1:0] r_opid;

    logic [SW-1:0] w_i;
    logic [MW-1:0] w_wr_addr, w_rd_addr;
    logic [NW-1:0] w_n1;
    assign w_i = r_i[SW-1:0];
    assign w_n1 = r_n - NW'(1);
    assign w_wr_addr = MW'(r_slot) * MW'(WAIT_DEPTH) + MW'(r_wcnt[r_slot]);
    assign w_rd_addr = MW'(r_slot) * MW'(WAIT_DEPTH) + MW'(w_n1);

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_buffer_index = r_oidx;
    assign o_woken_pid = r_opid;
    assign o_last = r_olast;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_SCAN;
            S_SCAN:   if (r_hit || r_i == CW'(NUM_SLOTS - 1)) n_state = S_DECIDE;
            S_DECIDE: begin
                n_state = S_DONE;
                if (!r_act && r_hit && !r_lock[r_slot]) n_state = S_FSCAN;
                if (r_act && r_hit && r_lock[r_slot]) n_state = S_WAKE;
                if (!r_act && !r_hit && r_fcnt != '0) n_state = S_SHIFT;
            end
            S_FSCAN:  if (r_i >= r_fcnt || r_free[w_i] == r_slot) n_state = S_SHIFT;
            S_SHIFT:  if (r_i + CW'(1) >= r_fcnt) n_state = S_DONE;
            S_WAKE:   if (r_n == '0) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_lock <= '0;
            r_fcnt <= CW'(NUM_SLOTS);
            r_ov <= 1'b0;
            r_olast <= 1'b0;
            r_opid <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_free[k] <= SW'(k);
                r_wcnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ov <= 1'b0;
            r_olast <= 1'b0;
            r_opid <= '0;
            unique case (r_state)
                S_IDLE: begin
                    r_act <= i_action;
                    r_blk <= i_block_number;
                    r_pid <= i_process_id;
                    r_i <= '0;
                    r_hit <= 1'b0;
                end
                S_SCAN: begin
                    if (r_used[w_i] && r_tag[w_i] == r_blk) begin
                        r_hit <= 1'b1;
                        r_slot <= w_i;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_DECIDE: begin
                    r_i <= '0;
                    r_oidx <= r_hit ? IDX_W'(r_slot)
                            : (!r_act && r_fcnt != '0) ? IDX_W'(r_free[0]) : '0;
                    if (!r_act) begin
                        if (r_hit && r_lock[r_slot]) begin
                            r_ov <= 1'b1;
                            r_olast <= 1'b1;
                            if (r_wcnt[r_slot] < NW'(WAIT_DEPTH)) begin
                                r_wmem[w_wr_addr] <= r_pid;
                                r_wcnt[r_slot] <= r_wcnt[r_slot] + NW'(1);
                                r_ost <= ST_QUEUED;
                            end else begin
                                r_ost <= ST_WAIT_FULL;
                            end
                        end else if (r_hit) begin
                            r_lock[r_slot] <= 1'b1;
                            r_ost <= ST_HIT;
                        end else if (r_fcnt == '0) begin
                            r_ov <= 1'b1;
                            r_olast <= 1'b1;
                            r_ost <= ST_NO_FREE;
                        end else begin
                            r_slot <= r_free[0];
                            r_tag[r_free[0]] <= r_blk;
                            r_used[r_free[0]] <= 1'b1;
                            r_lock[r_free[0]] <= 1'b1;
                            r_ost <= ST_MISS;
                        end
                    end else begin
                        if (r_hit && r_lock[r_slot]) begin
                            r_lock[r_slot] <= 1'b0;
                            r_n <= r_wcnt[r_slot];
                            r_wcnt[r_slot] <= '0;
                        end else begin
                            r_ov <= 1'b1;
                            r_olast <= 1'b1;
                            r_ost <= ST_NOT_BUSY;
                        end
                    end
                end
                S_FSCAN: begin
                    if (!(r_i >= r_fcnt || r_free[w_i] == r_slot)) r_i <= r_i + CW'(1);
                end
                S_SHIFT: begin
                    // Close the gap one entry per cycle.
                    if (r_i < r_fcnt) begin
                        if (r_i + CW'(1) < r_fcnt)
                            r_free[w_i] <= r_free[SW'(r_i + CW'(1))];
                        else
                            r_fcnt <= r_fcnt - CW'(1);
                    end
                    r_i <= r_i + CW'(1);
                end
                S_WAKE: begin
                    if (r_n != '0) begin
                        r_ov <= 1'b1;
                        r_ost <= ST_WOKEN;
                        r_opid <= r_wmem[w_rd_addr];
                        r_n <= w_n1;
                    end else begin
                        r_ost <= ST_RELEASED;
                        if (r_fcnt < CW'(NUM_SLOTS)) begin
                            r_free[SW'(r_fcnt)] <= r_slot;
                            r_fcnt <= r_fcnt + CW'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (!(r_ost == ST_QUEUED || r_ost == ST_WAIT_FULL
                          || r_ost == ST_NO_FREE || r_ost == ST_NOT_BUSY)) begin
                        r_ov <= 1'b1;
                        r_olast <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_IDLE) |-> !o_valid)
        else $error("output while idle");
    a_fcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CW'(NUM_SLOTS)) else $error("free count overflow");
    a_woken_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_WOKEN) |-> o_woken_pid == '0)
        else $error("stray pid");
`endif

endmodule
